// ----- rtl/bprm_pkg.sv -----
`timescale 1ns / 1ps

package bprm_pkg;

  // Number of device ids covered by the child maps (8..128)
  localparam int NUM_IDS  = 128;
  localparam int ID_IDX_W = $clog2(NUM_IDS);
  localparam logic [7:0] ID_LIMIT = 8'(NUM_IDS);

  // Request types
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_BYTE    = 3'd1;
  localparam logic [2:0] REQ_TIMEOUT = 3'd2;
  localparam logic [2:0] REQ_ENABLE  = 3'd3;
  localparam logic [2:0] REQ_DISABLE = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_POLL  = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_ACK   = 3'd2;
  localparam logic [2:0] KIND_NACK  = 3'd3;
  localparam logic [2:0] KIND_FOUND = 3'd4;
  localparam logic [2:0] KIND_LOST  = 3'd5;

  localparam logic [7:0] ACK_BYTE  = 8'd0;
  localparam logic [7:0] NACK_BYTE = 8'd1;

  localparam logic [6:0] FIRST_ID     = 7'd1;
  localparam logic [6:0] MAX_ID_RESET = 7'd4;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
    logic [6:0] child_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] device_id;
    logic [7:0] data_byte;
    logic       char_packet;
    logic       last;
  } res_t;

endpackage

// ----- rtl/bprm_in_if.sv -----
`timescale 1ns / 1ps

interface bprm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] rx_byte;
  logic [6:0] child_id;

  modport source (output valid, output req_type, output rx_byte, output child_id,
                  input ready);
  modport sink (input valid, input req_type, input rx_byte, input child_id,
                output ready);
endinterface

// ----- rtl/bprm_out_if.sv -----
`timescale 1ns / 1ps

interface bprm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] device_id;
  logic [7:0] data_byte;
  logic       char_packet;
  logic       last;

  modport source (output valid, output kind, output device_id, output data_byte,
                  output char_packet, output last, input ready);
  modport sink (input valid, input kind, input device_id, input data_byte,
                input char_packet, input last, output ready);
endinterface

// ----- rtl/bus_poll_receive_master.sv -----
`timescale 1ns / 1ps
// An item is registered at its transfer and processed once the result queue has room for two
// results; its results are registered in the result queue, from which they are offered.
// Throughput: one item per cycle while the result queue has room; an item that gives two results
// (ack and found) takes two output transfers, which the four-entry result queue absorbs.
// Reset (rst_n, synchronous, active low) clears both child maps, the poll and receive state,
// poll_delay and the result queue.

module bus_poll_receive_master import bprm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  bprm_in_if.sink     in_chan,
  bprm_out_if.source  out_chan
);

  logic [7:0]         poll_delay_r;
  logic [NUM_IDS-1:0] en_map_r, en_map_nxt;
  logic [NUM_IDS-1:0] pr_map_r, pr_map_nxt;
  logic [6:0]         polled_id_r, polled_id_nxt;
  logic [6:0]         max_id_r, max_id_nxt;
  logic [7:0]         tick_r, tick_nxt;
  logic               receiving_r, receiving_nxt;
  logic [6:0]         byte_cnt_r, byte_cnt_nxt;
  logic [5:0]         frame_len_r, frame_len_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic               char_r, char_nxt;

  logic               inq_vld_r;
  in_item_t           inq_r;

  res_t                  fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  logic       room, proc, pop;
  res_t       r0, r1;
  logic [1:0] n_res;

  // Combinational working values
  logic [7:0] tick_inc, pid_p1, sum_base, sum_new;
  logic [6:0] next_id;
  logic       pid_ok, next_ok, id_ok, rx_on;
  logic [5:0] flen;
  logic       chr;

  assign room = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign proc = inq_vld_r && room;
  assign pop  = out_chan.valid && out_chan.ready;

  assign in_chan.ready = !inq_vld_r || proc;

  always_comb begin
    en_map_nxt    = en_map_r;
    pr_map_nxt    = pr_map_r;
    polled_id_nxt = polled_id_r;
    max_id_nxt    = max_id_r;
    tick_nxt      = tick_r;
    receiving_nxt = receiving_r;
    byte_cnt_nxt  = byte_cnt_r;
    frame_len_nxt = frame_len_r;
    sum_nxt       = sum_r;
    char_nxt      = char_r;
    r0            = '0;
    r1            = '0;
    n_res         = 2'd0;

    tick_inc = (tick_r == 8'hFF) ? tick_r : tick_r + 8'd1;
    pid_p1   = {1'b0, polled_id_r} + 8'd1;
    next_id  = (pid_p1 > {1'b0, max_id_r}) ? FIRST_ID : pid_p1[6:0];
    pid_ok   = ({1'b0, polled_id_r} < ID_LIMIT);
    next_ok  = ({1'b0, next_id} < ID_LIMIT);
    id_ok    = (inq_r.child_id != 7'd0) && ({1'b0, inq_r.child_id} < ID_LIMIT);
    sum_base = (byte_cnt_r == 7'd0) ? 8'd0 : sum_r;
    sum_new  = sum_base + inq_r.rx_byte;
    flen     = (byte_cnt_r == 7'd0) ? inq_r.rx_byte[5:0] : frame_len_r;
    chr      = (byte_cnt_r == 7'd0) ? inq_r.rx_byte[7] : char_r;
    rx_on    = 1'b1;

    if (proc) begin
      unique case (inq_r.req_type)
        REQ_TICK: begin
          tick_nxt = tick_inc;
          if (!receiving_r && tick_inc >= poll_delay_r) begin
            tick_nxt      = 8'd0;
            polled_id_nxt = next_id;
            if (next_ok && en_map_r[next_id[ID_IDX_W-1:0]]) begin
              receiving_nxt = 1'b1;
              byte_cnt_nxt  = 7'd0;
              sum_nxt       = 8'd0;
              r0            = '{KIND_POLL, next_id, {1'b1, next_id}, 1'b0, 1'b1};
              n_res         = 2'd1;
            end
          end
        end
        REQ_BYTE: begin
          if (receiving_r) begin
            byte_cnt_nxt = byte_cnt_r + 7'd1;
            sum_nxt      = sum_new;
            if (byte_cnt_r == 7'd0) begin
              frame_len_nxt = inq_r.rx_byte[5:0];
              if (inq_r.rx_byte == 8'd0) begin
                // Empty answer: the device is there but has nothing to say
                rx_on         = 1'b0;
                receiving_nxt = 1'b0;
                if (pid_ok && !pr_map_r[polled_id_r[ID_IDX_W-1:0]]) begin
                  pr_map_nxt[polled_id_r[ID_IDX_W-1:0]] = 1'b1;
                  r0    = '{KIND_FOUND, polled_id_r, 8'd0, 1'b0, 1'b1};
                  n_res = 2'd1;
                end
              end else begin
                char_nxt = inq_r.rx_byte[7];
              end
            end
            if (rx_on) begin
              if (byte_cnt_r != 7'd0 && byte_cnt_r <= {1'b0, flen}) begin
                r0    = '{KIND_DATA, polled_id_r, inq_r.rx_byte, chr, 1'b1};
                n_res = 2'd1;
              end else if (byte_cnt_r > {1'b0, flen}) begin
                // Checksum byte closes the frame
                receiving_nxt = 1'b0;
                if (sum_new == 8'd0) begin
                  r0    = '{KIND_ACK, polled_id_r, ACK_BYTE, chr, 1'b1};
                  n_res = 2'd1;
                  if (pid_ok && !pr_map_r[polled_id_r[ID_IDX_W-1:0]]) begin
                    pr_map_nxt[polled_id_r[ID_IDX_W-1:0]] = 1'b1;
                    r0.last = 1'b0;
                    r1      = '{KIND_FOUND, polled_id_r, 8'd0, 1'b0, 1'b1};
                    n_res   = 2'd2;
                  end
                end else begin
                  r0    = '{KIND_NACK, polled_id_r, NACK_BYTE, chr, 1'b1};
                  n_res = 2'd1;
                end
              end
            end
          end
        end
        REQ_TIMEOUT: begin
          if (receiving_r) begin
            receiving_nxt = 1'b0;
            if (pid_ok && pr_map_r[polled_id_r[ID_IDX_W-1:0]]) begin
              pr_map_nxt[polled_id_r[ID_IDX_W-1:0]] = 1'b0;
              r0    = '{KIND_LOST, polled_id_r, 8'd0, 1'b0, 1'b1};
              n_res = 2'd1;
            end
          end
        end
        REQ_ENABLE: begin
          if (id_ok) begin
            en_map_nxt[inq_r.child_id[ID_IDX_W-1:0]] = 1'b1;
            pr_map_nxt[inq_r.child_id[ID_IDX_W-1:0]] = 1'b0;
            if (max_id_r < inq_r.child_id) begin
              max_id_nxt = inq_r.child_id;
            end
          end
        end
        REQ_DISABLE: begin
          if (id_ok) begin
            en_map_nxt[inq_r.child_id[ID_IDX_W-1:0]] = 1'b0;
            pr_map_nxt[inq_r.child_id[ID_IDX_W-1:0]] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_delay_r <= 8'd0;
      en_map_r     <= '0;
      pr_map_r     <= '0;
      polled_id_r  <= FIRST_ID;
      max_id_r     <= MAX_ID_RESET;
      tick_r       <= 8'd0;
      receiving_r  <= 1'b0;
      byte_cnt_r   <= 7'd0;
      frame_len_r  <= 6'd0;
      sum_r        <= 8'd0;
      char_r       <= 1'b0;
      inq_vld_r    <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        poll_delay_r <= cfg_wdata;
      end
      en_map_r    <= en_map_nxt;
      pr_map_r    <= pr_map_nxt;
      polled_id_r <= polled_id_nxt;
      max_id_r    <= max_id_nxt;
      tick_r      <= tick_nxt;
      receiving_r <= receiving_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      frame_len_r <= frame_len_nxt;
      sum_r       <= sum_nxt;
      char_r      <= char_nxt;
      if (in_chan.ready) begin
        inq_vld_r <= in_chan.valid;
      end
      wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(n_res);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_r + FIFO_CNT_W'(n_res) - FIFO_CNT_W'(pop);
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      inq_r <= '{in_chan.req_type, in_chan.rx_byte, in_chan.child_id};
    end
    if (n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= r0;
    end
    if (n_res == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_PTR_W'(1)] <= r1;
    end
  end

  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.kind        = fifo_r[rd_ptr_r].kind;
  assign out_chan.device_id   = fifo_r[rd_ptr_r].device_id;
  assign out_chan.data_byte   = fifo_r[rd_ptr_r].data_byte;
  assign out_chan.char_packet = fifo_r[rd_ptr_r].char_packet;
  assign out_chan.last        = fifo_r[rd_ptr_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_room_on_proc: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    else $error("item processed without room for two results");

  a_poll_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    polled_id_r != 7'd0 && polled_id_r <= max_id_r)
    else $error("polled id outside round robin range");

  a_poll_starts_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (n_res != 2'd0 && r0.kind == KIND_POLL) |=> receiving_r)
    else $error("poll issued without entering reception");

  a_two_results_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (n_res == 2'd2) |-> (r0.kind == KIND_ACK && r1.kind == KIND_FOUND))
    else $error("unexpected result pair");

endmodule
